>>> rtl/tdpf_pkg.sv
// tdpf_pkg: shared widths, limits and types for the trial-division prime finder.
// No dependencies; imported by every rtl module and the checker.
`timescale 1ns / 1ps

package tdpf_pkg;

    localparam int CAND_W          = 13;
    localparam int COUNT_W         = 11;
    localparam int TABLE_DEPTH     = 1024;
    localparam int ADDR_W          = 10;
    localparam int CANDIDATE_LIMIT = 8192;
    localparam int LIMIT_W         = 17;
    localparam int FIRST_CANDIDATE = 6;
    localparam int PRELOAD_COUNT   = 3;
    localparam int DIV_STEPS       = CAND_W;
    localparam int STEP_W          = 4;

    typedef logic [CAND_W-1:0]  cand_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [STEP_W-1:0]  step_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_status_t;

    // fixed primes held in the first table rows
    function automatic cand_t preload_prime(input logic [1:0] idx);
        cand_t p;
        case (idx)
            2'd0:    p = CAND_W'(2);
            2'd1:    p = CAND_W'(3);
            default: p = CAND_W'(5);
        endcase
        return p;
    endfunction

endpackage

>>> rtl/tdpf_table.sv
// tdpf_table: prime table memory, one write port and one registered read port.
// Rows 0..2 read as the preloaded primes. Depends on tdpf_pkg.
`timescale 1ns / 1ps

module tdpf_table (
    input  logic            clk,
    input  logic            wr_en,
    input  tdpf_pkg::addr_t wr_addr,
    input  tdpf_pkg::cand_t wr_data,
    input  tdpf_pkg::addr_t rd_addr,
    output tdpf_pkg::cand_t rd_data
);
    import tdpf_pkg::*;

    cand_t       mem [TABLE_DEPTH];
    cand_t       mem_q_reg;
    logic        pre_reg;
    logic [1:0]  pre_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg   <= mem[rd_addr];
        pre_reg     <= (rd_addr < ADDR_W'(PRELOAD_COUNT));
        pre_idx_reg <= rd_addr[1:0];
    end

    // preloaded rows are never written
    assign rd_data = pre_reg ? preload_prime(pre_idx_reg) : mem_q_reg;

endmodule

>>> rtl/tdpf_divider.sv
// tdpf_divider: restoring remainder unit, one quotient bit per cycle.
// Reports only whether the remainder is zero. Depends on tdpf_pkg.
`timescale 1ns / 1ps

module tdpf_divider (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  tdpf_pkg::cand_t        dividend,
    input  tdpf_pkg::cand_t        divisor,
    output tdpf_pkg::div_status_t  status
);
    import tdpf_pkg::*;

    logic          run_reg;
    logic          done_reg;
    step_t         cnt_reg;
    cand_t         rem_reg;
    cand_t         dvd_reg;
    cand_t         dsr_reg;
    logic [CAND_W:0] trial;
    cand_t         rem_next;
    logic          last_step;

    assign trial     = {rem_reg, dvd_reg[CAND_W-1]};
    assign last_step = (cnt_reg == STEP_W'(DIV_STEPS - 1));

    // trial < 2*divisor, so the difference fits CAND_W bits
    always_comb
    begin
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = CAND_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[CAND_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[CAND_W-2:0], 1'b0};
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

>>> rtl/trial_division_prime_finder_core.sv
// trial_division_prime_finder_core: top level, sequencer over the prime table
// and the shared remainder unit. Depends on tdpf_pkg, tdpf_table, tdpf_divider.
`timescale 1ns / 1ps

// Usage
//   Input: drive candidate and pulse start while busy is low; the item is taken
//   at that edge. Candidates normally rise from 6 upward.
//   Output: done is high for exactly one cycle with is_prime, prime_count and
//   table_full. The receiver cannot stall; the result must be taken that cycle.
// Sequencing
//   Out-of-range candidate (below 6): result in the next cycle.
//   Otherwise each stored prime tried passes through a table read, a load step,
//   the divider steps (one quotient bit each) and a status check. The result
//   appears in the cycle after the first divisor hit or the last stored prime.
//   The single 13-bit restoring divider serves every trial; one item at a time,
//   busy stays high meanwhile and start is ignored.
// Reset
//   rst_n (async, active low) returns to idle with 2, 3 and 5 stored and a count
//   of 3. Table rows above those are meaningless until a prime is written there.
// Table full
//   A prime found with the table full is still reported, with table_full set.

module trial_division_prime_finder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tdpf_pkg::cand_t     candidate,
    output logic                done,
    output logic                is_prime,
    output tdpf_pkg::count_t    prime_count,
    output logic                table_full
);
    import tdpf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_LOAD   = 4'b0100,
        ST_DIVIDE = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    cand_t        cand_reg, cand_next;
    addr_t        k_reg, k_next;
    count_t       count_reg, count_next;
    logic         done_reg, done_next;
    logic         prime_reg, prime_next;
    count_t       pcount_reg, pcount_next;
    logic         full_reg, full_next;

    logic         accept;
    logic         in_range;
    logic         last_k;
    logic         has_room;
    cand_t        rd_data;
    logic         div_start;
    div_status_t  div_st;
    logic         wr_en;

    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = (candidate >= CAND_W'(FIRST_CANDIDATE))
                   && ({{(LIMIT_W-CAND_W){1'b0}}, candidate} < LIMIT_W'(CANDIDATE_LIMIT));
    assign last_k   = (({1'b0, k_reg} + COUNT_W'(1)) == count_reg);
    assign has_room = (count_reg < COUNT_W'(TABLE_DEPTH));

    tdpf_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (cand_reg),
        .rd_addr (k_reg),
        .rd_data (rd_data)
    );

    tdpf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (rd_data),
        .status   (div_st)
    );

    always_comb
    begin
        state_next  = state_reg;
        cand_next   = cand_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        prime_next  = prime_reg;
        pcount_next = pcount_reg;
        full_next   = full_reg;
        div_start   = 1'b0;
        wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cand_next = candidate;
                    k_next    = '0;
                    if (in_range)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        // ignored item: report current count, nothing stored
                        done_next   = 1'b1;
                        prime_next  = 1'b0;
                        full_next   = 1'b0;
                        pcount_next = count_reg;
                    end
                end
            end
            ST_FETCH:
            begin
                // table read issued from k_reg
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (rd_data != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else if (last_k)
                begin
                    // zero row skipped; no divisor found
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    prime_next  = 1'b1;
                    wr_en       = has_room;
                    count_next  = has_room ? count_reg + COUNT_W'(1) : count_reg;
                    pcount_next = count_next;
                    full_next   = !has_room;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_st.done)
                begin
                    if (div_st.rem_zero)
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        prime_next  = 1'b0;
                        full_next   = 1'b0;
                        pcount_next = count_reg;
                    end
                    else if (last_k)
                    begin
                        state_next  = ST_IDLE;
                        done_next   = 1'b1;
                        prime_next  = 1'b1;
                        wr_en       = has_room;
                        count_next  = has_room ? count_reg + COUNT_W'(1) : count_reg;
                        pcount_next = count_next;
                        full_next   = !has_room;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_W'(PRELOAD_COUNT);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        k_reg      <= k_next;
        prime_reg  <= prime_next;
        pcount_reg <= pcount_next;
        full_reg   <= full_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign is_prime    = prime_reg;
    assign prime_count = pcount_reg;
    assign table_full  = full_reg;

endmodule

>>> rtl/tdpf_checker.sv
// tdpf_checker: port-level assertions for the prime finder core, bound to it.
// Depends on tdpf_pkg and trial_division_prime_finder_core.
`timescale 1ns / 1ps

module tdpf_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             done,
    input  logic             is_prime,
    input  tdpf_pkg::count_t prime_count,
    input  logic             table_full
);
    import tdpf_pkg::*;

    // a result only shows once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted item either starts work or answers at once
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item dropped");

    // full flag only on a prime
    a_full_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> is_prime)
        else $error("table_full without prime");

    // full flag only with a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (prime_count == COUNT_W'(TABLE_DEPTH)))
        else $error("table_full with room left");

endmodule

bind trial_division_prime_finder_core tdpf_checker u_tdpf_checker (.*);
